### hdl/irbb_pkg.sv
// ----------------------------------------------------------------------------
// irbb_pkg
// Shared constants and tables for the IR ring ball bearing estimator.
// ----------------------------------------------------------------------------
package irbb_pkg;

  localparam int COUNT_BITS_DEF = 8;
  localparam int CORDIC_STEPS   = 16;

  // Angles are held in units of 2^-16 degree.
  localparam int ZW = 26;
  localparam int DEG_FRAC = 16;

  localparam logic signed [ZW-1:0] DEG_22 = 26'sd1474560;
  localparam logic signed [ZW-1:0] DEG_67 = 26'sd4423680;
  localparam logic signed [ZW-1:0] DEG_90 = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG_112 = 26'sd7372800;
  localparam logic signed [ZW-1:0] DEG_157 = 26'sd10321920;
  localparam logic signed [ZW-1:0] DEG_180 = 26'sd11796480;

  localparam int ANGLE_OFFSET = 180;

  // Register indexes on the configuration port.
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_FOUND_LIMIT   = 1'b1;

  localparam logic [7:0] WINDOW_LENGTH_RST = 8'd100;
  localparam logic [7:0] FOUND_LIMIT_RST   = 8'd95;

  // atan(2^-i) in degrees, scaled by 2^16 and rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      4'd0:    a = 26'sd2949120;
      4'd1:    a = 26'sd1740967;
      4'd2:    a = 26'sd919879;
      4'd3:    a = 26'sd466945;
      4'd4:    a = 26'sd234379;
      4'd5:    a = 26'sd117304;
      4'd6:    a = 26'sd58666;
      4'd7:    a = 26'sd29335;
      4'd8:    a = 26'sd14668;
      4'd9:    a = 26'sd7334;
      4'd10:   a = 26'sd3667;
      4'd11:   a = 26'sd1833;
      4'd12:   a = 26'sd917;
      4'd13:   a = 26'sd458;
      4'd14:   a = 26'sd229;
      4'd15:   a = 26'sd115;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hdl/ir_ring_ball_bearing_core.sv
// ----------------------------------------------------------------------------
// ir_ring_ball_bearing_core
// Counts IR detector hits over a window and estimates the ball bearing by
// CORDIC, together with a nearness figure.
// ----------------------------------------------------------------------------
// An accumulating sample leaves busy low. The sample after
// a full window starts an estimate: busy is high through the minimum search
// over the counters, forming the vector, sixteen CORDIC iterations on the
// one shared add-and-shift unit, the sector clamp and registering the
// result, and the result is shown with done for one cycle after that. The
// receiver cannot stall the result, and a new sample may be started in the
// cycle that done is high.
module ir_ring_ball_bearing_core
  import irbb_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  ir_bits,
  output logic        done,
  output logic        ball_found,
  output logic [8:0]  bearing_code,
  output logic [7:0]  nearness,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int VW = COUNT_BITS + 24;  // CORDIC datapath
  localparam int NW = COUNT_BITS + 9;   // nearness dividend
  localparam int CW = COUNT_BITS + 8;   // found compare

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MIN   = 6'b000010,
    S_VEC   = 6'b000100,
    S_ROT   = 6'b001000,
    S_CLAMP = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [7:0]            window_length;
  logic [7:0]            found_limit;
  logic [COUNT_BITS-1:0] hit_counters [8];
  logic [7:0]            sample_count;

  logic [COUNT_BITS-1:0] mn;
  logic [2:0]            first;
  logic [2:0]            idx;
  logic [3:0]            iter;
  logic                  found;
  logic                  zero_vec;
  logic signed [VW-1:0]  x;
  logic signed [VW-1:0]  y;
  logic signed [ZW-1:0]  z;
  logic signed [ZW-1:0]  deg;
  logic [NW-1:0]         rem;
  logic [7:0]            quot;
  logic                  near_sat;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {24'd0, (paddr[2] == REG_FOUND_LIMIT) ? found_limit : window_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      found_limit   <= FOUND_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_WINDOW_LENGTH: window_length <= pwdata[7:0];
        REG_FOUND_LIMIT:   found_limit   <= pwdata[7:0];
        default:           ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  logic accept;
  logic counting;
  assign accept   = start && !busy;
  assign counting = (sample_count < window_length);

  // Vector of weights: the window length cancels in every difference.
  logic signed [VW-1:0] cnt_s [8];
  logic signed [VW-1:0] diff_a, diff_b, diff_c, diff_d;
  logic signed [VW-1:0] vx, vy, vx_s, vy_s;
  logic [NW-1:0]        dividend;
  logic [NW-1:0]        wl_ext;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      cnt_s[k] = $signed({{(VW-COUNT_BITS){1'b0}}, hit_counters[k]});
    end
    diff_a = cnt_s[4] - cnt_s[0];
    diff_b = cnt_s[3] + cnt_s[5] - cnt_s[1] - cnt_s[7];
    diff_c = cnt_s[6] - cnt_s[2];
    diff_d = cnt_s[5] + cnt_s[7] - cnt_s[1] - cnt_s[3];
    vx = (diff_a <<< 6) + (diff_a <<< 5) + (diff_a <<< 2)
       + (diff_b <<< 6) + (diff_b <<< 2) + (diff_b <<< 1) + diff_b;
    vy = (diff_c <<< 6) + (diff_c <<< 5) + (diff_c <<< 2)
       + (diff_d <<< 6) + (diff_d <<< 2) + (diff_d <<< 1) + diff_d;
    vx_s = vx <<< 12;
    vy_s = vy <<< 12;
    wl_ext   = NW'(window_length);
    dividend = ({{(NW-COUNT_BITS){1'b0}}, mn} << 8) - {{(NW-COUNT_BITS){1'b0}}, mn};
  end

  // Shared CORDIC step: arithmetic shifts give floor division by 2^i.
  logic signed [VW-1:0] dx, dy;
  logic signed [ZW-1:0] da;
  logic [NW-1:0]        div_sub;
  always_comb begin
    dx      = y >>> iter;
    dy      = x >>> iter;
    da      = atan_lut(iter);
    div_sub = wl_ext << (~iter[2:0]);
  end

  // Clamp to the half turn, then into the sector of the first minimum.
  logic signed [ZW-1:0] zc, ds;
  always_comb begin
    zc = z;
    if (zc > DEG_180) zc = DEG_180;
    if (zc < -DEG_180) zc = -DEG_180;
    if (zero_vec) zc = '0;
    ds = zc;
    case (first)
      3'd0: begin
        if (ds > DEG_22) ds = DEG_22;
        if (ds < -DEG_22) ds = -DEG_22;
      end
      3'd1: begin
        if (ds > DEG_67) ds = DEG_67;
        if (ds < DEG_22) ds = DEG_22;
      end
      3'd2: begin
        if (ds > DEG_112) ds = DEG_112;
        if (ds < DEG_67) ds = DEG_67;
      end
      3'd3: begin
        if (ds > DEG_157) ds = DEG_157;
        if (ds < DEG_112) ds = DEG_112;
      end
      3'd4: begin
        // The rear sector straddles the half turn, so the sign picks its side.
        if (ds > 0) begin
          if (ds < DEG_157) ds = DEG_157;
        end else if (ds > -DEG_157) begin
          ds = -DEG_157;
        end
      end
      3'd5: begin
        if (ds > -DEG_112) ds = -DEG_112;
        if (ds < -DEG_157) ds = -DEG_157;
      end
      3'd6: begin
        if (ds > -DEG_67) ds = -DEG_67;
        if (ds < -DEG_112) ds = -DEG_112;
      end
      default: begin
        if (ds > -DEG_22) ds = -DEG_22;
        if (ds < -DEG_67) ds = -DEG_67;
      end
    endcase
  end

  // Truncation toward zero of whole degrees.
  logic [ZW-1:0]     deg_mag;
  logic [7:0]        deg_whole;
  logic signed [9:0] deg_trunc;
  logic [9:0]        code_sum;
  always_comb begin
    deg_mag   = deg[ZW-1] ? ZW'(-deg) : ZW'(deg);
    deg_whole = deg_mag[DEG_FRAC +: 8];
    deg_trunc = deg[ZW-1] ? -$signed({2'b00, deg_whole}) : $signed({2'b00, deg_whole});
    code_sum  = 10'(deg_trunc + 10'sd180);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      for (int k = 0; k < 8; k++) hit_counters[k] <= '0;
      done         <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (counting) begin
              for (int k = 0; k < 8; k++) begin
                if (ir_bits[k] && !(&hit_counters[k])) begin
                  hit_counters[k] <= hit_counters[k] + COUNT_BITS'(1);
                end
              end
              sample_count <= sample_count + 8'd1;
            end else begin
              mn    <= hit_counters[0];
              first <= 3'd0;
              idx   <= 3'd1;
              state <= S_MIN;
            end
          end
        end
        S_MIN: begin
          if (hit_counters[idx] < mn) begin
            mn    <= hit_counters[idx];
            first <= idx;
          end
          idx <= idx + 3'd1;
          if (idx == 3'd7) state <= S_VEC;
        end
        S_VEC: begin
          found    <= ({{(CW-COUNT_BITS){1'b0}}, mn} <= CW'(found_limit));
          zero_vec <= (vx == 0) && (vy == 0);
          if (vx < 0) begin
            if (vy >= 0) begin
              x <= vy_s;
              y <= -vx_s;
              z <= DEG_90;
            end else begin
              x <= -vy_s;
              y <= vx_s;
              z <= -DEG_90;
            end
          end else begin
            x <= vx_s;
            y <= vy_s;
            z <= '0;
          end
          rem      <= dividend;
          near_sat <= (dividend >= (wl_ext << 8));
          quot     <= '0;
          iter     <= '0;
          state    <= S_ROT;
        end
        S_ROT: begin
          if (y > 0) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + da;
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - da;
          end
          // Restoring division for the nearness runs alongside the first eight steps.
          if (!iter[3] && (rem >= div_sub)) begin
            rem              <= rem - div_sub;
            quot[~iter[2:0]] <= 1'b1;
          end
          iter <= iter + 4'd1;
          if (iter == 4'(CORDIC_STEPS - 1)) state <= S_CLAMP;
        end
        S_CLAMP: begin
          deg   <= ds;
          state <= S_DONE;
        end
        S_DONE: begin
          ball_found   <= found;
          bearing_code <= found ? code_sum[8:0] : 9'd0;
          if (window_length == 8'd0) begin
            nearness <= 8'd0;
          end else if (near_sat) begin
            nearness <= 8'hFF;
          end else begin
            nearness <= quot;
          end
          sample_count <= '0;
          for (int k = 0; k < 8; k++) hit_counters[k] <= '0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/ir_ring_ball_bearing_core_test.sv
// ----------------------------------------------------------------------------
// ir_ring_ball_bearing_core_test
// Drives IR detector samples into the bearing estimator in random bursts,
// reprograms the window length and found limit between phases over the
// register port, and checks every estimate against a bit-exact predictor
// of the counters, the CORDIC angle, the sector clamp and the nearness.
// ----------------------------------------------------------------------------
module ir_ring_ball_bearing_core_test;
  import irbb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;
  localparam longint DEG_ONE = longint'(1) << DEG_FRAC;
  localparam int REAR_DETECTOR = 4;
  localparam longint ATAN_DEG [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct packed {
    logic       found;
    logic [8:0] code;
    logic [7:0] near;
  } bearing_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  ir_bits = 8'hFF;
  logic        done;
  logic        ball_found;
  logic [8:0]  bearing_code;
  logic [7:0]  nearness;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state.
  logic [COUNT_BITS_DEF-1:0] hit_count [8];
  logic [7:0] sample_count;
  logic [7:0] window_len;
  logic [7:0] found_lim;

  logic [7:0] ir_samples_q [$];
  bearing_t   expected_bearings [$];
  int         samples_sent = 0;
  int         samples_taken = 0;
  int         failures = 0;
  logic       sample_taken = 1'b0;
  int         burst_left = 1;
  int         gap_left = 0;

  ir_ring_ball_bearing_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .ir_bits(ir_bits),
    .done(done), .ball_found(ball_found), .bearing_code(bearing_code),
    .nearness(nearness), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic longint vector_angle(input longint x0, input longint y0);
    longint x, y, z, t, dx, dy;
    int i;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // Vectors in the left half plane are turned by a right angle first.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(DEG_90);
      end else begin
        x = -y; y = t; z = -longint'(DEG_90);
      end
    end
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_DEG[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_DEG[i];
      end
    end
    if (z > longint'(DEG_180)) z = longint'(DEG_180);
    if (z < -longint'(DEG_180)) z = -longint'(DEG_180);
    return z;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Returns 1 when the sample closes a window and an estimate is due.
  function automatic bit bearing_estimate(input logic [7:0] bits, output bearing_t est);
    logic [COUNT_BITS_DEF-1:0] least;
    int i, first;
    longint w [8];
    longint vx, vy, deg, d22, d67, d112, d157;
    int unsigned near_full;
    est = '0;
    if (sample_count < window_len) begin
      for (i = 0; i < 8; i++)
        if (bits[i] && hit_count[i] != COUNT_MAX) hit_count[i]++;
      sample_count++;
      return 1'b0;
    end
    least = hit_count[0];
    first = 0;
    for (i = 1; i < 8; i++)
      if (hit_count[i] < least) begin
        least = hit_count[i];
        first = i;
      end
    if (window_len == 0) begin
      near_full = 0;
    end else begin
      near_full = (int'(least) * 255) / int'(window_len);
      if (near_full > 255) near_full = 255;
    end
    est.near = near_full[7:0];
    est.found = (least <= found_lim);
    if (est.found) begin
      for (i = 0; i < 8; i++) w[i] = longint'(window_len) - longint'(hit_count[i]);
      vx = 100 * (w[0] - w[4]) + 71 * (w[1] - w[3] - w[5] + w[7]);
      vy = 100 * (w[2] - w[6]) + 71 * (w[1] + w[3] - w[5] - w[7]);
      deg = vector_angle(vx * 4096, vy * 4096);
      d22 = longint'(DEG_22);
      d67 = longint'(DEG_67);
      d112 = longint'(DEG_112);
      d157 = longint'(DEG_157);
      case (first)
        0: deg = clamp(deg, -d22, d22);
        1: deg = clamp(deg, d22, d67);
        2: deg = clamp(deg, d67, d112);
        3: deg = clamp(deg, d112, d157);
        REAR_DETECTOR: begin
          // The rear sector straddles the wrap, so the sign of the angle picks the half.
          if (deg > 0) begin
            if (deg < d157) deg = d157;
          end else if (deg > -d157) begin
            deg = -d157;
          end
        end
        5: deg = clamp(deg, -d157, -d112);
        6: deg = clamp(deg, -d112, -d67);
        default: deg = clamp(deg, -d67, -d22);
      endcase
      est.code = 9'(deg / DEG_ONE + ANGLE_OFFSET);
    end
    for (i = 0; i < 8; i++) hit_count[i] = '0;
    sample_count = '0;
    return 1'b1;
  endfunction

  function automatic void log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // A sample with the ball near detector centre: nearby detectors drop out more often.
  function automatic logic [7:0] ball_sample(input int centre);
    logic [7:0] b;
    int i, span, pct;
    for (i = 0; i < 8; i++) begin
      span = (i - centre + 8) % 8;
      if (span > 4) span = 8 - span;
      case (span)
        0: pct = 85;
        1: pct = 45;
        2: pct = 12;
        default: pct = 3;
      endcase
      b[i] = !($urandom_range(0, 99) < pct);
    end
    return b;
  endfunction

  always @(negedge clk) begin : driver
    if (rst) begin
      start <= 1'b0;
    end else if (start && !sample_taken) begin
      // Hold the sample until the block takes it.
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
      ir_bits <= 8'($urandom);
    end else if (ir_samples_q.size() != 0) begin
      start <= 1'b1;
      ir_bits <= ir_samples_q.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    bearing_t want, est;
    if (!rst) begin
      if (done) begin
        if (expected_bearings.size() == 0) begin
          log_failure($sformatf("unexpected result: found %0d bearing %0d nearness %0d",
                                ball_found, bearing_code, nearness));
        end else begin
          want = expected_bearings.pop_front();
          if (ball_found !== want.found || bearing_code !== want.code ||
              nearness !== want.near)
            log_failure($sformatf(
              "mismatch: expected found %0d bearing %0d nearness %0d, got %0d %0d %0d",
              want.found, want.code, want.near, ball_found, bearing_code, nearness));
        end
      end
      if (start && !busy) begin
        samples_taken++;
        if (bearing_estimate(ir_bits, est)) expected_bearings.push_back(est);
      end
    end
    sample_taken <= !rst && start && !busy;
  end

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_WINDOW_LENGTH) window_len = value;
    else found_lim = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] win, input logic [7:0] lim);
    write_reg(REG_WINDOW_LENGTH, win);
    write_reg(REG_FOUND_LIMIT, lim);
  endtask

  task automatic send(input logic [7:0] bits);
    ir_samples_q.push_back(bits);
    samples_sent++;
  endtask

  // Holds off further samples until every transfer is in and every estimate is out.
  task automatic settle();
    do @(negedge clk);
    while (samples_taken != samples_sent || expected_bearings.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  initial begin : timeout
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int i, k, n, windows, extra, mode, centre, phase, random_items;
    logic [7:0] win, lim;
    for (i = 0; i < 8; i++) hit_count[i] = '0;
    sample_count = '0;
    window_len = WINDOW_LENGTH_RST;
    found_lim = FOUND_LIMIT_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A zero window closes on every sample.
    configure(8'd0, 8'd0);
    send(8'h00);
    send(8'hFF);
    settle();

    // Ties between detectors; the lowest one picks the sector.
    configure(8'd3, 8'd255);
    send(8'hFF);
    send(8'h00);
    send(8'hAA);
    send(8'h55);
    settle();

    // Rear sector from both sides, then a window where nothing is seen.
    configure(8'd2, 8'd1);
    send(8'hEF); send(8'hEF); send(8'hFF);
    send(8'hCF); send(8'hEF); send(8'h00);
    send(8'hFF); send(8'hFF); send(8'hFF);
    settle();

    // Window shortened part way through: negative weights and saturated nearness.
    configure(8'd10, 8'd255);
    send(8'hFF); send(8'hFF); send(8'hFF); send(8'hFB); send(8'hFB);
    settle();
    configure(8'd2, 8'd200);
    send(8'h12);
    settle();

    random_items = 0;
    phase = 0;
    while (random_items < 700) begin
      phase++;
      if (phase == 2) win = 8'd255;
      else if ($urandom_range(0, 9) == 0) win = 8'd0;
      else win = 8'($urandom_range(1, 24));
      if (phase == 2) lim = 8'd255;
      else if ($urandom_range(0, 1) == 0) lim = 8'($urandom_range(0, 255));
      else lim = 8'($urandom_range(0, win));
      configure(win, lim);
      windows = (win == 8'd255) ? 1 : $urandom_range(2, 6);
      for (n = 0; n < windows; n++) begin
        mode = $urandom_range(0, 3);
        centre = $urandom_range(0, 7);
        for (k = 0; k <= win; k++) begin
          send(mode == 0 ? 8'($urandom) : ball_sample(centre));
          random_items++;
        end
      end
      // A part window left over carries into the next setting.
      extra = $urandom_range(0, win / 2);
      for (k = 0; k < extra; k++) begin
        send(ball_sample(centre));
        random_items++;
      end
      settle();
    end

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/irbb_pkg.sv
hdl/ir_ring_ball_bearing_core.sv
verif/ir_ring_ball_bearing_core_test.sv
